// ===== design/tree_lca_binary_lifting_defines.svh =====
// Assertion macros for the tree LCA block.
// Included by the RTL file that carries concurrent assertions; depends on nothing.
`ifndef TREE_LCA_BINARY_LIFTING_DEFINES_SVH
`define TREE_LCA_BINARY_LIFTING_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TLCA_ASSERT_IMP(name, clock, rstn, ante, cons, msg) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TLCA_ASSERT_NXT(name, clock, rstn, ante, cons, msg) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tlca_pkg.sv =====
// Package for the tree LCA block: sizes, table row layout, mode and state codes.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package tlca_pkg;

	localparam int NODES   = 1024;
	localparam int LEVELS  = 6;
	localparam int NODE_W  = $clog2(NODES);
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int DEPTH_W = LEVELS;
	localparam int MODE_W  = 2;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [LVL_W-1:0]   lvl_t;
	typedef logic [DEPTH_W-1:0] depth_t;

	// one table row per node: its depth and its 2^j ancestors
	typedef struct packed {
		depth_t                  depth;
		node_t [LEVELS-1:0]      anc;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	localparam node_t  LAST_NODE = node_t'(NODES - 1);
	localparam lvl_t   LVL_TOP   = lvl_t'(LEVELS - 1);
	localparam depth_t DEPTH_MAX = '1;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_BUILD = 2'd2,
		MODE_QUERY = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_W_WR,
		ST_B_PTR,
		ST_B_WR,
		ST_D_WALK,
		ST_D_FIN,
		ST_Q_LOAD,
		ST_Q_LIFT,
		ST_Q_JUMP,
		ST_Q_FINAL,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== design/tlca_ifs.sv =====
// Valid/ready channel interfaces: command words in, result words out.
// Depends on tlca_pkg.
`default_nettype none

interface tlca_cmd_if import tlca_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	node_t              first_node;
	node_t              second_node;

	modport source (output valid, output mode, output first_node, output second_node,
		input ready);
	modport sink (input valid, input mode, input first_node, input second_node,
		output ready);
endinterface

interface tlca_rsp_if import tlca_pkg::*; ();
	logic   valid;
	logic   ready;
	node_t  ancestor_node;
	logic   status;

	modport source (output valid, output ancestor_node, output status, input ready);
	modport sink (input valid, input ancestor_node, input status, output ready);
endinterface

`default_nettype wire

// ===== design/tree_lca_binary_lifting.sv =====
// Lowest-common-ancestor engine by binary lifting over one node table in RAM.
// Depends on tlca_pkg, tlca_ifs, tlca_ram and tree_lca_binary_lifting_defines.svh.
//
// Usage: command words arrive on cmd (mode, first_node, second_node), one result
// word per command leaves on rsp (ancestor_node, status). Each node owns one RAM
// row holding its six 2^j ancestors and its depth; every step is one RAM access
// on each of two read ports. The sequencer steps per command are:
//   write parent : read row, write row back
//   query        : load, 6 lift steps, 6 joint jump steps, final read; the jump
//                  steps and final read are skipped when the deeper node lifts onto the other
//   build        : a pointer read and a row write per node for levels 1..5, then
//                  a depth walk and a row write per node
//   clear        : one row per cycle
// One command is in flight at a time; cmd.ready is high only while idle.
// Reset starts a sweep that zeroes every row; cmd.ready stays low
// until it ends. A finished result sits in the output register while rsp.ready
// is low; the next command may be accepted meanwhile, but its own result waits
// until the register is free.
`default_nettype none
`include "tree_lca_binary_lifting_defines.svh"

module tree_lca_binary_lifting import tlca_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	tlca_cmd_if.sink     cmd,
	tlca_rsp_if.source   rsp
);

	state_t state_q, state_d;
	node_t  i_q, i_d;
	lvl_t   lvl_q, lvl_d;
	lvl_t   j_q, j_d;
	logic   flag_q, flag_d;
	node_t  u_q, u_d;
	node_t  v_q, v_d;
	depth_t diff_q, diff_d;
	depth_t d_q, d_d;
	node_t  res_anc_q, res_anc_d;
	logic   res_status_q, res_status_d;
	logic   out_valid_q;
	node_t  out_anc_q;
	logic   out_status_q;
	logic   out_load;

	logic             ram_we;
	node_t            ram_waddr;
	row_t             ram_wdata;
	node_t            ra_addr, rb_addr;
	logic [ROW_W-1:0] ra_data, rb_data;
	row_t             ra_row, rb_row;

	tlca_ram #(.WIDTH(ROW_W), .DEPTH(NODES)) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.ra_addr (ra_addr),
		.ra_data (ra_data),
		.rb_addr (rb_addr),
		.rb_data (rb_data)
	);

	assign ra_row = row_t'(ra_data);
	assign rb_row = row_t'(rb_data);

	assign cmd.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.ancestor_node = out_anc_q;
	assign rsp.status        = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			i_q         <= '0;
			lvl_q       <= '0;
			j_q         <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			lvl_q   <= lvl_d;
			j_q     <= j_d;
			flag_q  <= flag_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		u_q          <= u_d;
		v_q          <= v_d;
		diff_q       <= diff_d;
		d_q          <= d_d;
		res_anc_q    <= res_anc_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			out_anc_q    <= res_anc_q;
			out_status_q <= res_status_q;
		end
	end

	always_comb begin
		node_t nx_u;
		node_t nx_v;
		logic  too_deep;

		state_d      = state_q;
		i_d          = i_q;
		lvl_d        = lvl_q;
		j_d          = j_q;
		flag_d       = flag_q;
		u_d          = u_q;
		v_d          = v_q;
		diff_d       = diff_q;
		d_d          = d_q;
		res_anc_d    = res_anc_q;
		res_status_d = res_status_q;
		ra_addr      = u_q;
		rb_addr      = v_q;
		ram_we       = 1'b0;
		ram_waddr    = i_q;
		ram_wdata    = '0;
		out_load     = 1'b0;
		nx_u         = u_q;
		nx_v         = v_q;
		too_deep     = 1'b0;

		unique case (state_q)
			ST_INIT, ST_CLR: begin
				ram_we = 1'b1;
				if (i_q == LAST_NODE) begin
					res_anc_d    = '0;
					res_status_d = 1'b0;
					state_d      = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
				end else begin
					i_d = i_q + node_t'(1);
				end
			end
			ST_IDLE: begin
				if (cmd.valid) begin
					unique case (mode_t'(cmd.mode))
						MODE_CLEAR: begin
							i_d     = '0;
							state_d = ST_CLR;
						end
						MODE_WRITE: begin
							u_d     = cmd.first_node;
							v_d     = cmd.second_node;
							ra_addr = cmd.first_node;
							state_d = ST_W_WR;
						end
						MODE_BUILD: begin
							i_d     = '0;
							lvl_d   = lvl_t'(1);
							flag_d  = 1'b0;
							ra_addr = '0;
							state_d = ST_B_PTR;
						end
						MODE_QUERY: begin
							u_d     = cmd.first_node;
							v_d     = cmd.second_node;
							ra_addr = cmd.first_node;
							rb_addr = cmd.second_node;
							state_d = ST_Q_LOAD;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_W_WR: begin
				// node 0 is the root sentinel and keeps no parent
				if (u_q != '0) begin
					ram_we           = 1'b1;
					ram_waddr        = u_q;
					ram_wdata        = ra_row;
					ram_wdata.anc[0] = v_q;
				end
				res_anc_d    = '0;
				res_status_d = 1'b0;
				state_d      = ST_DONE;
			end
			ST_B_PTR: begin
				ra_addr = i_q;
				rb_addr = ra_row.anc[lvl_q - lvl_t'(1)];
				state_d = ST_B_WR;
			end
			ST_B_WR: begin
				ram_we               = 1'b1;
				ram_wdata            = ra_row;
				ram_wdata.anc[lvl_q] = rb_row.anc[lvl_q - lvl_t'(1)];
				if (i_q == LAST_NODE) begin
					i_d     = '0;
					ra_addr = '0;
					if (lvl_q == LVL_TOP) begin
						u_d     = '0;
						d_d     = '0;
						j_d     = LVL_TOP;
						rb_addr = '0;
						state_d = ST_D_WALK;
					end else begin
						lvl_d   = lvl_q + lvl_t'(1);
						state_d = ST_B_PTR;
					end
				end else begin
					i_d     = i_q + node_t'(1);
					ra_addr = i_q + node_t'(1);
					state_d = ST_B_PTR;
				end
			end
			ST_D_WALK: begin
				if (ra_row.anc[j_q] != '0) begin
					nx_u = ra_row.anc[j_q];
					d_d  = d_q | (depth_t'(1) << j_q);
				end
				u_d     = nx_u;
				ra_addr = nx_u;
				rb_addr = i_q;
				if (j_q == '0) begin
					state_d = ST_D_FIN;
				end else begin
					j_d = j_q - lvl_t'(1);
				end
			end
			ST_D_FIN: begin
				too_deep        = (ra_row.anc[0] != '0);
				ram_we          = 1'b1;
				ram_wdata       = rb_row;
				ram_wdata.depth = too_deep ? DEPTH_MAX : d_q;
				flag_d          = flag_q | too_deep;
				if (i_q == LAST_NODE) begin
					res_anc_d    = '0;
					res_status_d = flag_q | too_deep;
					state_d      = ST_DONE;
				end else begin
					i_d     = i_q + node_t'(1);
					u_d     = i_q + node_t'(1);
					d_d     = '0;
					j_d     = LVL_TOP;
					ra_addr = i_q + node_t'(1);
					rb_addr = i_q + node_t'(1);
					state_d = ST_D_WALK;
				end
			end
			ST_Q_LOAD: begin
				// deeper node goes to u
				if (ra_row.depth < rb_row.depth) begin
					nx_u   = v_q;
					nx_v   = u_q;
					diff_d = rb_row.depth - ra_row.depth;
				end else begin
					diff_d = ra_row.depth - rb_row.depth;
				end
				u_d     = nx_u;
				v_d     = nx_v;
				ra_addr = nx_u;
				rb_addr = nx_v;
				j_d     = '0;
				state_d = ST_Q_LIFT;
			end
			ST_Q_LIFT: begin
				if (diff_q[j_q]) begin
					nx_u = ra_row.anc[j_q];
				end
				u_d     = nx_u;
				ra_addr = nx_u;
				if (j_q == LVL_TOP) begin
					state_d = ST_Q_JUMP;
				end else begin
					j_d = j_q + lvl_t'(1);
				end
			end
			ST_Q_JUMP: begin
				if (j_q == LVL_TOP && u_q == v_q) begin
					res_anc_d    = u_q;
					res_status_d = 1'b0;
					state_d      = ST_DONE;
				end else begin
					if (ra_row.anc[j_q] != rb_row.anc[j_q]) begin
						nx_u = ra_row.anc[j_q];
						nx_v = rb_row.anc[j_q];
					end
					u_d     = nx_u;
					v_d     = nx_v;
					ra_addr = nx_u;
					rb_addr = nx_v;
					if (j_q == '0) begin
						state_d = ST_Q_FINAL;
					end else begin
						j_d = j_q - lvl_t'(1);
					end
				end
			end
			ST_Q_FINAL: begin
				res_anc_d    = ra_row.anc[0];
				res_status_d = 1'b0;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`TLCA_ASSERT_IMP(a_no_wr_in_query, clk, arst_n, (state_q == ST_Q_LOAD || state_q == ST_Q_LIFT || state_q == ST_Q_JUMP || state_q == ST_Q_FINAL), !ram_we, "table written during a query")
	`TLCA_ASSERT_IMP(a_rsp_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_DONE), "result word raised outside done")
	`TLCA_ASSERT_NXT(a_init_sweep_whole, clk, arst_n, (state_q == ST_INIT && i_q != LAST_NODE), (state_q == ST_INIT), "reset sweep cut short")
	`TLCA_ASSERT_IMP(a_fin_row_is_node, clk, arst_n, (state_q == ST_D_FIN || state_q == ST_B_WR), (ram_we && ram_waddr == i_q), "build writes a row other than the current node")

endmodule

`default_nettype wire

// ===== design/tlca_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports (read-old).
// No dependencies.
`default_nettype none

module tlca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    ra_addr,
	output logic [WIDTH-1:0] ra_data,
	input  logic [AW-1:0]    rb_addr,
	output logic [WIDTH-1:0] rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

`default_nettype wire
